FILE: rtl/mcpf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the motor command framer.
// Used by every module of the block; depends on nothing.
package mcpf_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_DEV_ADDR  = 8'd0;
    localparam logic [7:0] CFG_SPD_CODE  = 8'd1;
    localparam logic [7:0] CFG_RST_CODE  = 8'd2;

    // Configuration reset values
    localparam logic [7:0] DEV_ADDR_RST  = 8'd128;
    localparam logic [7:0] SPD_CODE_RST  = 8'd37;
    localparam logic [7:0] RST_CODE_RST  = 8'd20;

    // Command opcodes
    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // CRC-16 generator polynomial (init zero, MSB first)
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte positions inside a packet
    localparam logic [3:0] POS_ADDR     = 4'd0;
    localparam logic [3:0] POS_CODE     = 4'd1;
    localparam logic [3:0] POS_M1_B3    = 4'd2;
    localparam logic [3:0] POS_M1_B2    = 4'd3;
    localparam logic [3:0] POS_M1_B1    = 4'd4;
    localparam logic [3:0] POS_M1_B0    = 4'd5;
    localparam logic [3:0] POS_M2_B3    = 4'd6;
    localparam logic [3:0] POS_M2_B2    = 4'd7;
    localparam logic [3:0] POS_M2_B1    = 4'd8;
    localparam logic [3:0] POS_M2_B0    = 4'd9;
    localparam logic [3:0] LAST_SPEED   = 4'd11;
    localparam logic [3:0] LAST_RESET   = 4'd3;

    // Input item
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] motor1_speed;
        logic signed [31:0] motor2_speed;
    } t_cmd_in;

    // Result item
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_res_out;

    // Classified command held between front and back
    typedef struct packed {
        logic        is_reset;
        logic [3:0]  last_pos;
        logic [31:0] m1;
        logic [31:0] m2;
    } t_cmd;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] spd_code;
        logic [7:0] rst_code;
    } t_cfg;

    // Handshake between front queue and back serializer
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_hs;

    // Feed one byte into the CRC, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/mcpf_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
// Depends on mcpf_pkg.
module mcpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  mcpf_pkg::t_cmd_in i_cmd,
    output logic              full,
    output mcpf_pkg::t_cmd_hs o_hs,
    input  logic              i_hs_pop
);
    import mcpf_pkg::*;

    t_cmd        r_mem [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_cmd        w_cls;
    logic        w_wr;
    logic        w_rd;

    // Classify the incoming command
    always_comb begin
        w_cls.is_reset = (i_cmd.opcode == OP_RESET);
        w_cls.last_pos = (i_cmd.opcode == OP_RESET) ? LAST_RESET : LAST_SPEED;
        w_cls.m1       = i_cmd.motor1_speed;
        w_cls.m2       = i_cmd.motor2_speed;
    end

    assign full  = (r_cnt == 2'd2);
    assign w_wr  = push && !full;
    assign w_rd  = i_hs_pop && (r_cnt != 2'd0);

    // Advance pointers and count
    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the accepted command
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cls;
        end
    end

    assign o_hs.valid = (r_cnt != 2'd0);
    assign o_hs.cmd   = r_mem[r_rp];

endmodule

FILE: rtl/mcpf_back.sv
`timescale 1ns / 1ps
// Back end: serializes one command, runs the CRC and buffers the bytes in a
// two-entry result queue, a byte per cycle when not full. Depends on mcpf_pkg.
module mcpf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcpf_pkg::t_cfg     i_cfg,
    input  mcpf_pkg::t_cmd_hs  i_hs,
    output logic               o_hs_pop,
    output logic               empty,
    input  logic               pop,
    output mcpf_pkg::t_res_out o_res
);
    import mcpf_pkg::*;

    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    t_res_out    r_obuf [2];
    logic        r_owp, n_owp;
    logic        r_orp, n_orp;
    logic [1:0]  r_ocnt, n_ocnt;
    logic        w_rd;
    logic        w_emit;
    logic        w_last;
    logic        w_crc_hi;
    logic [7:0]  w_data;
    logic [7:0]  w_byte;
    t_res_out    w_res;

    assign w_rd   = pop && (r_ocnt != 2'd0);
    assign w_emit = i_hs.valid && ((r_ocnt != 2'd2) || w_rd);

    assign w_last   = (r_pos == i_hs.cmd.last_pos);
    assign w_crc_hi = (r_pos == (i_hs.cmd.last_pos - 4'd1));

    // Select the data byte for the current position
    always_comb begin
        case (r_pos)
            POS_ADDR:  w_data = i_cfg.dev_addr;
            POS_CODE:  w_data = i_hs.cmd.is_reset ? i_cfg.rst_code : i_cfg.spd_code;
            POS_M1_B3: w_data = i_hs.cmd.m1[31:24];
            POS_M1_B2: w_data = i_hs.cmd.m1[23:16];
            POS_M1_B1: w_data = i_hs.cmd.m1[15:8];
            POS_M1_B0: w_data = i_hs.cmd.m1[7:0];
            POS_M2_B3: w_data = i_hs.cmd.m2[31:24];
            POS_M2_B2: w_data = i_hs.cmd.m2[23:16];
            POS_M2_B1: w_data = i_hs.cmd.m2[15:8];
            POS_M2_B0: w_data = i_hs.cmd.m2[7:0];
            default:   w_data = 8'h00;
        endcase
    end

    // Pick data or CRC byte and flag the final one
    always_comb begin
        if (w_last) begin
            w_byte = r_crc[7:0];
        end else if (w_crc_hi) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = w_data;
        end
        w_res.tx_byte   = w_byte;
        w_res.last_byte = w_last;
    end

    // Advance position and CRC; clear CRC at packet start
    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (w_emit) begin
            n_pos = w_last ? POS_ADDR : (r_pos + 4'd1);
            if (!w_last && !w_crc_hi) begin
                n_crc = crc_feed((r_pos == POS_ADDR) ? 16'h0000 : r_crc, w_data);
            end
        end
    end

    assign o_hs_pop = w_emit && w_last;

    // Result queue pointers
    always_comb begin
        n_owp  = w_emit ? ~r_owp : r_owp;
        n_orp  = w_rd ? ~r_orp : r_orp;
        n_ocnt = r_ocnt + {1'b0, w_emit} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_ADDR;
            r_crc  <= 16'h0000;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_owp  <= n_owp;
            r_orp  <= n_orp;
            r_ocnt <= n_ocnt;
        end
    end

    // Hold the emitted beat
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obuf[r_owp] <= w_res;
        end
    end

    assign empty = (r_ocnt == 2'd0);
    assign o_res = r_obuf[r_orp];

endmodule

FILE: rtl/motor_command_packet_framer.sv
`timescale 1ns / 1ps
// Motor command packet framer. Each accepted command becomes one packet of bytes on the
// result queue: a speed command gives 12 beats (address, command code, motor 1 and motor 2
// speeds big-endian, CRC high, CRC low), an encoder reset gives 4 beats (address, code, CRC
// high, CRC low); last_byte marks the CRC low byte. The CRC is CRC-16 polynomial 0x1021,
// initial value zero, restarted for every packet. The serializer emits one byte per cycle
// while the result queue has room; a two-entry command queue in front lets new commands
// arrive while a packet is still going out. cfg_ready is always high.
// Depends on mcpf_pkg, mcpf_front and mcpf_back.
module motor_command_packet_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mcpf_pkg::t_cmd_in  i_cmd,
    output logic               empty,
    input  logic               pop,
    output mcpf_pkg::t_res_out o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import mcpf_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_cmd_hs w_hs;
    logic    w_hs_pop;

    assign o_cfg_ready = 1'b1;

    // Decode configuration writes; drop unknown indexes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEV_ADDR: n_cfg.dev_addr = i_cfg_data;
                CFG_SPD_CODE: n_cfg.spd_code = i_cfg_data;
                CFG_RST_CODE: n_cfg.rst_code = i_cfg_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= DEV_ADDR_RST;
            r_cfg.spd_code <= SPD_CODE_RST;
            r_cfg.rst_code <= RST_CODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    mcpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_cmd    (i_cmd),
        .full     (full),
        .o_hs     (w_hs),
        .i_hs_pop (w_hs_pop)
    );

    mcpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_hs     (w_hs),
        .o_hs_pop (w_hs_pop),
        .empty    (empty),
        .pop      (pop),
        .o_res    (o_res)
    );

endmodule

FILE: bench/motor_command_packet_framer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the motor command packet framer: drives commands and register
// writes, predicts every packet byte with a local CRC-16 framer and checks each result beat.
// Depends on mcpf_pkg and motor_command_packet_framer.
module motor_command_packet_framer_test;

    import mcpf_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         SETTLE_CYCLES   = 32;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [7:0] CFG_UNUSED_LO   = 8'd3;
    localparam logic [7:0] CFG_UNUSED_HI   = 8'hFF;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    t_cmd_in    i_cmd       = '0;
    logic       empty;
    logic       pop         = 1'b0;
    t_res_out   o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data  = '0;

    // Local copy of the framing registers
    logic [7:0] cur_addr     = DEV_ADDR_RST;
    logic [7:0] cur_spd_code = SPD_CODE_RST;
    logic [7:0] cur_rst_code = RST_CODE_RST;

    t_res_out   pending_bytes[$];
    int         error_count  = 0;
    int         quiet_cycles = 0;
    int         tx_idle_pct  = 17;
    int         rx_idle_pct  = 74;
    int         rx_hold_left = 0;

    motor_command_packet_framer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // CRC-16, polynomial 0x1021, one bit at a time MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ data[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Append the expected beats of one packet
    function automatic void frame_command(input t_cmd_in cmd);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [31:0] m1;
        logic [31:0] m2;
        t_res_out    beat;
        m1 = cmd.motor1_speed;
        m2 = cmd.motor2_speed;
        body.push_back(cur_addr);
        if (cmd.opcode == OP_RESET) begin
            body.push_back(cur_rst_code);
        end else begin
            body.push_back(cur_spd_code);
            for (int s = 24; s >= 0; s -= 8) body.push_back(m1[s +: 8]);
            for (int s = 24; s >= 0; s -= 8) body.push_back(m2[s +: 8]);
        end
        crc = '0;
        foreach (body[i]) begin
            crc            = crc16_step(crc, body[i]);
            beat.tx_byte   = body[i];
            beat.last_byte = 1'b0;
            pending_bytes.push_back(beat);
        end
        beat.tx_byte   = crc[15:8];
        beat.last_byte = 1'b0;
        pending_bytes.push_back(beat);
        beat.tx_byte   = crc[7:0];
        beat.last_byte = 1'b1;
        pending_bytes.push_back(beat);
    endfunction

    function automatic t_cmd_in make_cmd(input logic op, input logic [31:0] m1,
                                         input logic [31:0] m2);
        t_cmd_in c;
        c.opcode       = op;
        c.motor1_speed = m1;
        c.motor2_speed = m2;
        return c;
    endfunction

    // Mostly random speeds, with the corners mixed in
    function automatic logic [31:0] rand_speed();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s got %02h expected %02h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one command; leave push high so the next beat can follow directly
    task automatic send_cmd(input t_cmd_in cmd);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push  <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        frame_command(cmd);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_DEV_ADDR: cur_addr     = data;
            CFG_SPD_CODE: cur_spd_code = data;
            CFG_RST_CODE: cur_rst_code = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_framing(input logic [7:0] addr, input logic [7:0] spd,
                               input logic [7:0] rst);
        write_reg(CFG_DEV_ADDR, addr);
        write_reg(CFG_SPD_CODE, spd);
        write_reg(CFG_RST_CODE, rst);
    endtask

    // Drop push, wait for every expected beat, then let the serializer go quiet
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_cmd(make_cmd(OP_SPEED, 32'h0000_0000, 32'h0000_0000));
        send_cmd(make_cmd(OP_RESET, 32'h0000_0000, 32'h0000_0000));
        send_cmd(make_cmd(OP_SPEED, 32'h1234_5678, 32'hFFFF_FFFF));
        drain_results();
    endtask

    task automatic test_speed_extremes();
        send_cmd(make_cmd(OP_SPEED, 32'h7FFF_FFFF, 32'h8000_0000));
        send_cmd(make_cmd(OP_SPEED, 32'h8000_0000, 32'h7FFF_FFFF));
        send_cmd(make_cmd(OP_SPEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_SPEED, 32'hAAAA_AAAA, 32'h5555_5555));
        send_cmd(make_cmd(OP_SPEED, 32'h5555_5555, 32'hAAAA_AAAA));
        // speeds on a reset command must not reach the packet
        send_cmd(make_cmd(OP_RESET, 32'hFFFF_FFFF, 32'h8000_0000));
        drain_results();
    endtask

    task automatic test_register_extremes();
        set_framing(8'h00, 8'h00, 8'h00);
        send_cmd(make_cmd(OP_SPEED, 32'hFFFF_FFFF, 32'h0000_0000));
        send_cmd(make_cmd(OP_RESET, 32'h0000_0000, 32'h0000_0000));
        drain_results();
        set_framing(8'hFF, 8'hFF, 8'hFF);
        send_cmd(make_cmd(OP_SPEED, 32'h0000_0000, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        drain_results();
        // writes to unmapped indexes must leave the registers alone
        write_reg(CFG_UNUSED_LO, 8'h5A);
        write_reg(CFG_UNUSED_HI, 8'hA5);
        send_cmd(make_cmd(OP_SPEED, 32'h0102_0304, 32'hF0E0_D0C0));
        send_cmd(make_cmd(OP_RESET, 32'h0000_0000, 32'h0000_0000));
        drain_results();
        set_framing(DEV_ADDR_RST, SPD_CODE_RST, RST_CODE_RST);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int blk = 0; blk < 2; blk++) begin
            set_framing(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
            write_reg(8'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
                      8'($urandom_range(255)));
            repeat (count / 2) begin
                send_cmd(make_cmd(($urandom_range(99) < 30) ? OP_RESET : OP_SPEED,
                                  rand_speed(), rand_speed()));
            end
            drain_results();
        end
    endtask

    // Hold the receiver off while commands keep coming so the input stalls
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        rx_hold_left = HOLD_OFF_CYCLES;
        repeat (24) send_cmd(make_cmd(OP_SPEED, rand_speed(), rand_speed()));
        drain_results();
    endtask

    // Receiver: random pop, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_res_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected beat, tx_byte", o_res.tx_byte, 8'h00);
            end else begin
                want = pending_bytes.pop_front();
                if (o_res.tx_byte !== want.tx_byte) begin
                    report_mismatch("tx_byte", o_res.tx_byte, want.tx_byte);
                end
                if (o_res.last_byte !== want.last_byte) begin
                    report_mismatch("last_byte", {7'd0, o_res.last_byte},
                                    {7'd0, want.last_byte});
                end
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_speed_extremes();
        test_register_extremes();
        test_random_traffic(17, 74, 110);
        test_random_traffic(74, 17, 110);
        test_random_traffic(0, 0, 110);
        test_output_stall();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
